@@ src/c_token_scanner_assert.svh @@
// ----------------------------------------------------------------------------
// c_token_scanner_assert.svh
// Assertion macros shared by the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef C_TOKEN_SCANNER_ASSERT_SVH
`define C_TOKEN_SCANNER_ASSERT_SVH

// Checked only out of reset.
`define CTOK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CTOK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ctok_pkg.sv @@
// ----------------------------------------------------------------------------
// ctok_pkg
// Types and constants of the C token scanner.
// ----------------------------------------------------------------------------
package ctok_pkg;

    localparam int MAX_TOKEN_LEN = 127;
    localparam int LINE_BITS     = 16;
    localparam int COLUMN_BITS   = 12;
    localparam int LEN_BITS      = 7;

    localparam logic [1:0] CLS_IDENT   = 2'd0;
    localparam logic [1:0] CLS_CONST   = 2'd1;
    localparam logic [1:0] CLS_SPECIAL = 2'd2;

    typedef enum logic [11:0] {
        M_IDLE          = 12'b0000_0000_0001,
        M_IDENT         = 12'b0000_0000_0010,
        M_NUMBER        = 12'b0000_0000_0100,
        M_DOT           = 12'b0000_0000_1000,
        M_FRACTION      = 12'b0000_0001_0000,
        M_QUOTE         = 12'b0000_0010_0000,
        M_QUOTE_ESC     = 12'b0000_0100_0000,
        M_SLASH         = 12'b0000_1000_0000,
        M_LINE_COMMENT  = 12'b0001_0000_0000,
        M_BLOCK_COMMENT = 12'b0010_0000_0000,
        M_BLOCK_STAR    = 12'b0100_0000_0000,
        M_OP            = 12'b1000_0000_0000
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } ctok_in_t;

    typedef struct packed {
        logic [1:0]             token_class;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [LEN_BITS-1:0]    token_length;
        logic                   too_long;
        logic                   unterminated;
        logic                   last_of_run;
    } ctok_token_t;

    typedef struct packed {
        scan_mode_t             mode;
        logic [7:0]             pending_symbol;
        logic [LINE_BITS-1:0]   line_count;
        logic [COLUMN_BITS-1:0] column_count;
        logic [LINE_BITS-1:0]   tok_line;
        logic [COLUMN_BITS-1:0] tok_column;
        logic [LEN_BITS-1:0]    tok_count;
        logic                   overflow_seen;
    } ctok_state_t;

    // Results produced by one accepted request, first in order first.
    typedef struct packed {
        logic [1:0]  count;
        ctok_token_t first;
        ctok_token_t second;
    } ctok_push_t;

endpackage

@@ src/ctok_result_fifo.sv @@
// ----------------------------------------------------------------------------
// ctok_result_fifo
// Three-entry result queue: takes up to two tokens a cycle, gives one.
// ----------------------------------------------------------------------------
module ctok_result_fifo
    import ctok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctok_push_t  push,
    input  logic        pop,
    output logic        out_valid,
    output ctok_token_t out_data,
    output logic        has_room
);

    ctok_token_t entry_reg [3];
    ctok_token_t entry_next [3];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [1:0]  base;
    logic        do_pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[0];
    // room for the worst case of two results
    assign has_room  = (count_reg <= 2'd1);
    assign do_pop    = pop && out_valid;

    always_comb
    begin
        entry_next = entry_reg;
        base       = count_reg;
        if (do_pop)
        begin
            entry_next[0] = entry_reg[1];
            entry_next[1] = entry_reg[2];
            base          = count_reg - 2'd1;
        end
        for (int i = 0; i < 3; i++)
        begin
            if ((push.count != 2'd0) && (2'(i) == base))
                entry_next[i] = push.first;
            if ((push.count == 2'd2) && (2'(i) == base + 2'd1))
                entry_next[i] = push.second;
        end
        count_next = base + push.count;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

endmodule

@@ src/ctok_step.sv @@
// ----------------------------------------------------------------------------
// ctok_step
// One scanner step: next state and up to two tokens for one byte.
// ----------------------------------------------------------------------------
module ctok_step
    import ctok_pkg::*;
(
    input  ctok_state_t st,
    input  ctok_in_t    req,
    output ctok_state_t st_next,
    output ctok_push_t  push
);

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LEN_BITS-1:0]    LEN_MAX  = LEN_BITS'(MAX_TOKEN_LEN);

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_CR;
    endfunction

    // > < + - ! = & |
    function automatic logic is_pair_start(input logic [7:0] c);
        return c == 8'h3E || c == 8'h3C || c == 8'h2B || c == 8'h2D ||
               c == 8'h21 || c == 8'h3D || c == 8'h26 || c == 8'h7C;
    endfunction

    function automatic logic makes_pair(input logic [7:0] f, input logic [7:0] s);
        logic ok;
        case (f)
            8'h3E:   ok = (s == 8'h3E) || (s == 8'h3D);
            8'h3C:   ok = (s == 8'h3C) || (s == 8'h3D);
            8'h2B:   ok = (s == 8'h2B);
            8'h2D:   ok = (s == 8'h2D) || (s == 8'h3E);
            8'h21:   ok = (s == 8'h3D);
            8'h3D:   ok = (s == 8'h3D);
            8'h26:   ok = (s == 8'h26);
            8'h7C:   ok = (s == 8'h7C);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    logic [7:0]  b;
    logic        emit_a;
    logic        emit_b;
    logic        add_char;
    logic        fresh;
    logic [1:0]  cls_a;
    logic        unterm_a;
    ctok_token_t tok_a;
    ctok_token_t tok_b;
    ctok_state_t ns;

    assign b = req.text_byte;

    always_comb
    begin
        ns       = st;
        emit_a   = 1'b0;
        emit_b   = 1'b0;
        add_char = 1'b0;
        fresh    = 1'b0;
        cls_a    = CLS_SPECIAL;
        unterm_a = 1'b0;
        tok_a    = '0;
        tok_b    = '0;

        if (req.end_of_text)
        begin
            // flush whatever token is open; comments are dropped
            case (st.mode)
                M_IDENT:
                begin
                    emit_a = 1'b1;
                    cls_a  = CLS_IDENT;
                end
                M_NUMBER, M_FRACTION:
                begin
                    emit_a = 1'b1;
                    cls_a  = CLS_CONST;
                end
                M_DOT, M_SLASH, M_OP:
                begin
                    emit_a = 1'b1;
                    cls_a  = CLS_SPECIAL;
                end
                M_QUOTE, M_QUOTE_ESC:
                begin
                    emit_a   = 1'b1;
                    cls_a    = CLS_CONST;
                    unterm_a = 1'b1;
                end
                default: ;
            endcase
            ns.mode           = M_IDLE;
            ns.pending_symbol = 8'd0;
            ns.line_count     = LINE_BITS'(1);
            ns.column_count   = '0;
        end
        else
        begin
            if (b == CH_NEWLINE)
            begin
                if (st.line_count < LINE_MAX)
                    ns.line_count = st.line_count + LINE_BITS'(1);
                ns.column_count = '0;
            end
            else if (st.column_count < COL_MAX)
            begin
                ns.column_count = st.column_count + COLUMN_BITS'(1);
            end

            case (st.mode)
                M_IDENT:
                begin
                    if (is_letter(b) || is_digit(b) || b == CH_UNDERSCORE)
                        add_char = 1'b1;
                    else
                    begin
                        emit_a = 1'b1;
                        cls_a  = CLS_IDENT;
                        fresh  = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(b) || b == CH_DOT)
                        add_char = 1'b1;
                    else
                    begin
                        emit_a = 1'b1;
                        cls_a  = CLS_CONST;
                        fresh  = 1'b1;
                    end
                end
                M_DOT:
                begin
                    if (is_digit(b))
                    begin
                        add_char = 1'b1;
                        ns.mode  = M_FRACTION;
                    end
                    else
                    begin
                        emit_a = 1'b1;
                        cls_a  = CLS_SPECIAL;
                        fresh  = 1'b1;
                    end
                end
                M_FRACTION:
                begin
                    if (is_digit(b))
                        add_char = 1'b1;
                    else
                    begin
                        emit_a = 1'b1;
                        cls_a  = CLS_CONST;
                        fresh  = 1'b1;
                    end
                end
                M_QUOTE:
                begin
                    add_char = 1'b1;
                    if (b == CH_BACKSLASH)
                        ns.mode = M_QUOTE_ESC;
                    else if (b == st.pending_symbol)
                    begin
                        emit_a = 1'b1;
                        cls_a  = CLS_CONST;
                    end
                end
                M_QUOTE_ESC:
                begin
                    add_char = 1'b1;
                    ns.mode  = M_QUOTE;
                end
                M_SLASH:
                begin
                    if (b == CH_SLASH)
                        ns.mode = M_LINE_COMMENT;
                    else if (b == CH_STAR)
                        ns.mode = M_BLOCK_COMMENT;
                    else
                    begin
                        emit_a = 1'b1;
                        cls_a  = CLS_SPECIAL;
                        fresh  = 1'b1;
                    end
                end
                M_LINE_COMMENT:
                begin
                    if (b == CH_NEWLINE)
                        ns.mode = M_IDLE;
                end
                M_BLOCK_COMMENT:
                begin
                    if (b == CH_STAR)
                        ns.mode = M_BLOCK_STAR;
                end
                M_BLOCK_STAR:
                begin
                    if (b == CH_SLASH)
                        ns.mode = M_IDLE;
                    else if (b != CH_STAR)
                        ns.mode = M_BLOCK_COMMENT;
                end
                M_OP:
                begin
                    emit_a = 1'b1;
                    cls_a  = CLS_SPECIAL;
                    if (makes_pair(st.pending_symbol, b))
                        add_char = 1'b1;
                    else
                        fresh = 1'b1;
                end
                default:
                begin
                    ns.mode = M_IDLE;
                    fresh   = 1'b1;
                end
            endcase
        end

        // length holds at the limit and marks the overflow
        if (add_char)
        begin
            if (st.tok_count >= LEN_MAX)
                ns.overflow_seen = 1'b1;
            else
                ns.tok_count = st.tok_count + LEN_BITS'(1);
        end

        if (emit_a)
            ns.mode = M_IDLE;

        tok_a.token_class  = cls_a;
        tok_a.start_line   = ns.tok_line;
        tok_a.start_column = ns.tok_column;
        tok_a.token_length = ns.tok_count;
        tok_a.too_long     = ns.overflow_seen;
        tok_a.unterminated = unterm_a;
        tok_a.last_of_run  = 1'b0;

        // first byte of a new token, starting from the updated position
        if (fresh && !is_space(b))
        begin
            ns.tok_line      = ns.line_count;
            ns.tok_column    = ns.column_count;
            ns.tok_count     = LEN_BITS'(1);
            ns.overflow_seen = 1'b0;
            if (is_letter(b))
                ns.mode = M_IDENT;
            else if (is_digit(b))
                ns.mode = M_NUMBER;
            else if (b == CH_DOT)
                ns.mode = M_DOT;
            else if (b == CH_SQUOTE || b == CH_DQUOTE)
            begin
                ns.pending_symbol = b;
                ns.mode           = M_QUOTE;
            end
            else if (b == CH_SLASH)
                ns.mode = M_SLASH;
            else if (is_pair_start(b))
            begin
                ns.pending_symbol = b;
                ns.mode           = M_OP;
            end
            else
            begin
                emit_b  = 1'b1;
                ns.mode = M_IDLE;
            end
        end

        tok_b.token_class  = CLS_SPECIAL;
        tok_b.start_line   = ns.tok_line;
        tok_b.start_column = ns.tok_column;
        tok_b.token_length = ns.tok_count;
        tok_b.too_long     = ns.overflow_seen;
        tok_b.unterminated = 1'b0;
        tok_b.last_of_run  = 1'b1;
    end

    always_comb
    begin
        st_next     = ns;
        push.count  = {1'b0, emit_a} + {1'b0, emit_b};
        push.first  = emit_a ? tok_a : tok_b;
        push.second = tok_b;
        push.first.last_of_run = !(emit_a && emit_b);
    end

endmodule

@@ src/c_token_scanner.sv @@
// ----------------------------------------------------------------------------
// c_token_scanner
// Byte-serial lexical scanner for C-style source text.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_ready carry one request per byte (text_byte,
//                 end_of_text). end_of_text flushes the open token, ignores
//                 the byte and restarts at line 1, column 0.
//   out channel : out_valid/out_ready carry one token per transfer
//                 (class, start line/column, length, flags, last_of_run).
//   Output      : a token is queued when the request that closes it is
//                 taken and shows on out_data once earlier tokens are taken.
//   Throughput  : one request per cycle while in_ready is high. A byte that
//                 both ends a token and is a one-character special makes two
//                 tokens; the queue drains one token per cycle while out_ready
//                 is high, so in_ready drops while two or more tokens are held.
//   Stall       : while out_ready is low the three-entry queue fills; in_ready
//                 stays high while at most one token is queued.
//   Reset       : rst_n clears the queue and puts the scanner idle at line 1.
// ----------------------------------------------------------------------------
module c_token_scanner
    import ctok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ctok_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ctok_token_t out_data
);

`include "c_token_scanner_assert.svh"

    ctok_state_t state_reg;
    ctok_state_t state_next;
    ctok_push_t  step_push;
    ctok_push_t  fifo_push;
    logic        in_take;
    logic        has_room;

    assign in_ready = has_room;
    assign in_take  = in_valid && in_ready;

    // scan step: state and the current byte in, tokens out
    ctok_step u_step (
        .st      (state_reg),
        .req     (in_data),
        .st_next (state_next),
        .push    (step_push)
    );

    // only a taken request pushes tokens
    always_comb
    begin
        fifo_push       = step_push;
        fifo_push.count = in_take ? step_push.count : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode           <= M_IDLE;
            state_reg.pending_symbol <= 8'd0;
            state_reg.line_count     <= LINE_BITS'(1);
            state_reg.column_count   <= '0;
            state_reg.tok_line       <= '0;
            state_reg.tok_column     <= '0;
            state_reg.tok_count      <= '0;
            state_reg.overflow_seen  <= 1'b0;
        end
        else if (in_take)
        begin
            state_reg <= state_next;
        end
    end

    // result register / queue between the scanner and the receiver
    ctok_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .pop       (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .has_room  (has_room)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `CTOK_ASSERT(a_len_nonzero, out_valid |-> out_data.token_length != '0,
        "token of zero length")
    `CTOK_ASSERT(a_col_nonzero, out_valid |-> out_data.start_column != '0,
        "token starts at column zero")
    `CTOK_ASSERT(a_stall_only_full, !in_ready |-> out_valid,
        "input stalled with no result queued")
    `CTOK_ASSERT(a_eot_restart,
        (in_take && in_data.end_of_text) |=>
            (state_reg.line_count == LINE_BITS'(1) && state_reg.column_count == '0),
        "position not restarted after end of text")
    // queue count is cleared asynchronously as soon as rst_n goes low
    `CTOK_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid,
        "result shown during reset")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for c_token_scanner. Source text goes in as byte
// requests. A cycle-free model of the scanner predicts every token, and each
// token that comes out is checked against the oldest prediction. Four idling
// phases are run, plus a long receiver hold-off and a run of overlong
// identifier, number and string tokens.
// ----------------------------------------------------------------------------
module testbench;
    import ctok_pkg::*;

    localparam int STALL_LIMIT  = 5000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 64;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 10;    // settle time after the last token
    localparam int PHASE_ITEMS  = 120;   // pending requests are topped up to this per idling phase

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    ctok_in_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    ctok_token_t out_data;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    c_token_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Stimulus bookkeeping
    // ------------------------------------------------------------------
    ctok_in_t    pending_reqs[$];     // requests not yet put on the bus
    ctok_token_t expected_tokens[$];  // predicted tokens, oldest first
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_tag       = 0;  // bumped to ask for a long hold-off
    int          hold_seen      = 0;
    int          hold_left      = 0;
    logic        req_taken      = 1'b0;
    int          stall_cycles   = 0;
    int          reqs_accepted  = 0;
    int          tokens_checked = 0;
    int          too_long_seen  = 0;
    int          unterm_seen    = 0;
    int          mismatch_count = 0;

    // the eleven two-character operators, back to back
    string op_pairs = ">>>=<<<=++--->!===&&||";
    // single specials, pair starts and token starters that end up alone
    string lone_marks = "><+-!=&|/.(){};,#_@[]";

    // ------------------------------------------------------------------
    // Scanner model: position counters, the open token and the mode
    // ------------------------------------------------------------------
    scan_mode_t             lex_mode     = M_IDLE;
    logic [7:0]             open_quote   = 8'd0;  // quote char or operator start
    logic [LINE_BITS-1:0]   cur_line     = LINE_BITS'(1);
    logic [COLUMN_BITS-1:0] cur_col      = '0;
    logic [LINE_BITS-1:0]   tok_line     = '0;
    logic [COLUMN_BITS-1:0] tok_col      = '0;
    logic [LEN_BITS-1:0]    tok_len      = '0;
    logic                   tok_overflow = 1'b0;
    ctok_token_t            step_tokens[$];       // tokens of the current byte

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR;
    endfunction

    function automatic bit opens_pair(logic [7:0] c);
        case (c)
            ">", "<", "+", "-", "!", "=", "&", "|": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit pairs_with(logic [7:0] first, logic [7:0] second);
        case (first)
            ">": return second == ">" || second == "=";
            "<": return second == "<" || second == "=";
            "+": return second == "+";
            "-": return second == "-" || second == ">";
            "!": return second == "=";
            "=": return second == "=";
            "&": return second == "&";
            "|": return second == "|";
            default: return 1'b0;
        endcase
    endfunction

    task automatic open_token();
        tok_line     = cur_line;
        tok_col      = cur_col;
        tok_len      = LEN_BITS'(1);
        tok_overflow = 1'b0;
    endtask

    // length sticks at the maximum, overflow remembers that it did
    task automatic grow_token();
        if (tok_len >= MAX_TOKEN_LEN)
            tok_overflow = 1'b1;
        else
            tok_len = tok_len + 1'b1;
    endtask

    task automatic close_token(logic [1:0] cls, logic unterm);
        ctok_token_t t;
        t.token_class  = cls;
        t.start_line   = tok_line;
        t.start_column = tok_col;
        t.token_length = tok_len;
        t.too_long     = tok_overflow;
        t.unterminated = unterm;
        t.last_of_run  = 1'b0;
        step_tokens.push_back(t);
        lex_mode = M_IDLE;
    endtask

    // a byte seen from the idle mode: may start a token or be one
    task automatic start_from(logic [7:0] b);
        if (!is_blank(b))
        begin
            open_token();
            if (is_alpha(b))
                lex_mode = M_IDENT;
            else if (is_num(b))
                lex_mode = M_NUMBER;
            else if (b == ".")
                lex_mode = M_DOT;
            else if (b == "'" || b == "\"")
            begin
                open_quote = b;
                lex_mode   = M_QUOTE;
            end
            else if (b == "/")
                lex_mode = M_SLASH;
            else if (opens_pair(b))
            begin
                open_quote = b;
                lex_mode   = M_OP;
            end
            else
                close_token(CLS_SPECIAL, 1'b0);
        end
    endtask

    // Advance the model by one accepted request and queue its tokens.
    task automatic lex_byte(ctok_in_t req);
        logic [7:0]  b;
        bit          restart;
        ctok_token_t t;
        b       = req.text_byte;
        restart = 1'b0;
        step_tokens.delete();
        if (req.end_of_text)
        begin
            // flush: open comments vanish, open quotes are flagged
            case (lex_mode)
                M_IDENT:                 close_token(CLS_IDENT, 1'b0);
                M_NUMBER, M_FRACTION:    close_token(CLS_CONST, 1'b0);
                M_DOT, M_SLASH, M_OP:    close_token(CLS_SPECIAL, 1'b0);
                M_QUOTE, M_QUOTE_ESC:    close_token(CLS_CONST, 1'b1);
                default: ;
            endcase
            lex_mode   = M_IDLE;
            open_quote = 8'd0;
            cur_line   = LINE_BITS'(1);
            cur_col    = '0;
        end
        else
        begin
            // both counters saturate; newline also restarts the column
            if (b == CH_NL)
            begin
                if (cur_line != '1)
                    cur_line = cur_line + 1'b1;
                cur_col = '0;
            end
            else if (cur_col != '1)
                cur_col = cur_col + 1'b1;

            case (lex_mode)
                M_IDENT:
                    if (is_alpha(b) || is_num(b) || b == "_")
                        grow_token();
                    else
                    begin
                        close_token(CLS_IDENT, 1'b0);
                        restart = 1'b1;
                    end
                M_NUMBER:
                    if (is_num(b) || b == ".")
                        grow_token();
                    else
                    begin
                        close_token(CLS_CONST, 1'b0);
                        restart = 1'b1;
                    end
                M_DOT:
                    if (is_num(b))
                    begin
                        grow_token();
                        lex_mode = M_FRACTION;
                    end
                    else
                    begin
                        close_token(CLS_SPECIAL, 1'b0);
                        restart = 1'b1;
                    end
                M_FRACTION:
                    if (is_num(b))
                        grow_token();
                    else
                    begin
                        close_token(CLS_CONST, 1'b0);
                        restart = 1'b1;
                    end
                M_QUOTE:
                begin
                    grow_token();
                    if (b == "\\")
                        lex_mode = M_QUOTE_ESC;
                    else if (b == open_quote)
                        close_token(CLS_CONST, 1'b0);
                end
                M_QUOTE_ESC:
                begin
                    grow_token();
                    lex_mode = M_QUOTE;
                end
                M_SLASH:
                    if (b == "/")
                        lex_mode = M_LINE_COMMENT;
                    else if (b == "*")
                        lex_mode = M_BLOCK_COMMENT;
                    else
                    begin
                        close_token(CLS_SPECIAL, 1'b0);
                        restart = 1'b1;
                    end
                M_LINE_COMMENT:
                    if (b == CH_NL)
                        lex_mode = M_IDLE;
                M_BLOCK_COMMENT:
                    if (b == "*")
                        lex_mode = M_BLOCK_STAR;
                M_BLOCK_STAR:
                    if (b == "/")
                        lex_mode = M_IDLE;
                    else if (b != "*")
                        lex_mode = M_BLOCK_COMMENT;
                M_OP:
                    if (pairs_with(open_quote, b))
                    begin
                        grow_token();
                        close_token(CLS_SPECIAL, 1'b0);
                    end
                    else
                    begin
                        close_token(CLS_SPECIAL, 1'b0);
                        restart = 1'b1;
                    end
                default:
                begin
                    lex_mode = M_IDLE;
                    restart  = 1'b1;
                end
            endcase

            if (restart)
                start_from(b);
        end

        foreach (step_tokens[i])
        begin
            t             = step_tokens[i];
            t.last_of_run = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    task automatic push_byte(logic [7:0] b);
        ctok_in_t r;
        r.text_byte   = b;
        r.end_of_text = 1'b0;
        pending_reqs.push_back(r);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // end-of-text request; the byte rides along but is ignored
    task automatic push_flush();
        ctok_in_t r;
        r.text_byte   = 8'($urandom_range(0, 255));
        r.end_of_text = 1'b1;
        pending_reqs.push_back(r);
    endtask

    // One random source fragment. Mostly well-formed lexemes with random
    // content, glued together with or without whitespace so that tokens
    // often end on the first byte of the next one; some noise and flushes.
    task automatic add_fragment();
        int         pick;
        int         n;
        int         k;
        logic [7:0] q;
        pick = $urandom_range(0, 99);
        if (pick < 16)
        begin
            // identifier, now and then an overlong one
            push_byte(8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25)));
            n = ($urandom_range(0, 49) == 0) ? $urandom_range(120, 140)
                                             : $urandom_range(0, 7);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0:       push_byte(8'("a" + $urandom_range(0, 25)));
                    1:       push_byte(8'("A" + $urandom_range(0, 25)));
                    2:       push_byte(8'("0" + $urandom_range(0, 9)));
                    default: push_byte("_");
                endcase
            end
        end
        else if (pick < 28)
        begin
            // number with dots
            push_byte(8'("0" + $urandom_range(0, 9)));
            repeat ($urandom_range(0, 5))
                push_byte(8'($urandom_range(0, 4) == 0 ? "." : "0" + $urandom_range(0, 9)));
        end
        else if (pick < 34)
        begin
            // fraction, or a lone dot when no digit follows
            push_byte(".");
            repeat ($urandom_range(0, 3))
                push_byte(8'("0" + $urandom_range(0, 9)));
        end
        else if (pick < 44)
        begin
            // char or string literal with escapes; sometimes left open
            q = $urandom_range(0, 1) ? "'" : "\"";
            push_byte(q);
            n = ($urandom_range(0, 49) == 0) ? 130 : $urandom_range(0, 6);
            repeat (n)
            begin
                k = $urandom_range(0, 9);
                if (k < 2)
                begin
                    push_byte("\\");
                    push_byte(8'($urandom_range(0, 255)));
                end
                else if (k == 2)
                    push_byte(CH_NL);
                else
                    push_byte(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 99) < 85)
                push_byte(q);
        end
        else if (pick < 50)
        begin
            push_text("//");
            repeat ($urandom_range(0, 6))
                push_byte(8'($urandom_range(32, 126)));
            push_byte(CH_NL);
        end
        else if (pick < 56)
        begin
            // block comment; stars and slashes inside test the close rule
            push_text("/*");
            repeat ($urandom_range(0, 6))
            begin
                case ($urandom_range(0, 4))
                    0:       push_byte("*");
                    1:       push_byte("/");
                    2:       push_byte(CH_NL);
                    3:       push_byte(CH_SPACE);
                    default: push_byte(8'("a" + $urandom_range(0, 25)));
                endcase
            end
            if ($urandom_range(0, 1))
                push_byte("*");
            push_text("*/");
        end
        else if (pick < 68)
        begin
            k = $urandom_range(0, 10);
            push_byte(op_pairs[2*k]);
            push_byte(op_pairs[2*k+1]);
        end
        else if (pick < 78)
            push_byte(lone_marks[$urandom_range(0, lone_marks.len() - 1)]);
        else if (pick < 88)
        begin
            case ($urandom_range(0, 3))
                0:       push_byte(CH_SPACE);
                1:       push_byte(CH_TAB);
                2:       push_byte(CH_NL);
                default: push_byte(CH_CR);
            endcase
        end
        else if (pick < 94)
            push_byte(8'($urandom_range(0, 255)));
        else
            push_flush();

        if ($urandom_range(0, 99) < 40)
            push_byte(CH_SPACE);
    endtask

    // ------------------------------------------------------------------
    // Driver: new request at the falling edge once the last one is taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_data  <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, and a long hold-off on request of the
    // sequencer, counted here so the sender keeps pushing meanwhile.
    always @(negedge clk)
    begin
        if (hold_seen != hold_tag)
        begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Accepted requests feed the model at the rising edge.
    always @(posedge clk)
    begin
        req_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            lex_byte(in_data);
            reqs_accepted <= reqs_accepted + 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each token against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : token_check
        ctok_token_t want;
        bit          bad;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("%0t: token with none expected: cls %0d line %0d col %0d len %0d",
                             $realtime, out_data.token_class, out_data.start_line,
                             out_data.start_column, out_data.token_length);
            end
            else
            begin
                want = expected_tokens.pop_front();
                tokens_checked = tokens_checked + 1;
                too_long_seen  = too_long_seen + want.too_long;
                unterm_seen    = unterm_seen + want.unterminated;
                bad = (out_data.token_class  !== want.token_class)  ||
                      (out_data.start_line   !== want.start_line)   ||
                      (out_data.start_column !== want.start_column) ||
                      (out_data.token_length !== want.token_length) ||
                      (out_data.too_long     !== want.too_long)     ||
                      (out_data.unterminated !== want.unterminated) ||
                      (out_data.last_of_run  !== want.last_of_run);
                if (bad)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: token mismatch (cls line col len long unt last)",
                                 $realtime);
                        $display("  want %0d %0d %0d %0d %b %b %b",
                                 want.token_class, want.start_line, want.start_column,
                                 want.token_length, want.too_long, want.unterminated,
                                 want.last_of_run);
                        $display("  got  %0d %0d %0d %0d %b %b %b",
                                 out_data.token_class, out_data.start_line,
                                 out_data.start_column, out_data.token_length,
                                 out_data.too_long, out_data.unterminated,
                                 out_data.last_of_run);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: %0d cycles without progress, %0d tokens outstanding",
                     stall_cycles, expected_tokens.size());
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int leftover;

        // Directed opening: identifier with underscore and digit, a fraction
        // cut by a dot, lone dot, lone slash, underscore on its own, an
        // operator start ended by newline, an escaped char literal, an empty
        // block comment, the two extreme byte values, and an open string
        // ending in a backslash cut off by end of text.
        push_text("a_9 .5./_+");
        push_byte(CH_NL);
        push_text("'\\''/**/");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("\"\\");
        push_flush();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase

            // receiver goes quiet while the sender keeps offering bytes
            if (phase == 0)
                hold_tag = hold_tag + 1;

            while (pending_reqs.size() < PHASE_ITEMS)
                add_fragment();

            if (phase == 0)
            begin
                // Overlong identifier, number and string, then a few short
                // tokens and a flush.
                push_byte("x");
                repeat (139) push_byte("q");
                push_byte(CH_SPACE);
                repeat (130) push_byte("7");
                push_byte(";");
                push_byte("\"");
                repeat (150) push_byte("s");
                push_byte("\"");
                push_text("a+b");
                push_byte(CH_NL);
                push_text("z;w");
                push_flush();
            end

            while (pending_reqs.size() != 0)
                @(posedge clk);
        end

        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        leftover = expected_tokens.size();
        $display("summary: %0d byte requests, %0d tokens checked, %0d mismatches",
                 reqs_accepted, tokens_checked, mismatch_count);
        $display("summary: %0d overlong, %0d unterminated; four idling phases, one hold-off",
                 too_long_seen, unterm_seen);
        if (mismatch_count == 0 && leftover == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
